// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising clk edge outside reset.
`define AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant checked on every rising clk edge outside reset.
`define AST_ALW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// ----- sv/mtlb_pkg.sv -----
// Types and constants of the TLB address translator.
`default_nettype none
package mtlb_pkg;

	localparam int VA_W    = 32;
	localparam int VPN_W   = 20;
	localparam int PFN_W   = 20;
	localparam int ASID_W  = 6;
	localparam int SLOT_W  = 6;
	localparam int FLAG_W  = 4;
	localparam int FAULT_W = 3;
	localparam int OFF_W   = 12;

	typedef logic [1:0] op_t;
	localparam op_t OP_TRANSLATE = 2'd0;
	localparam op_t OP_READ      = 2'd1;
	localparam op_t OP_WRITE     = 2'd2;
	localparam op_t OP_PROBE     = 2'd3;

	typedef logic [FAULT_W-1:0] fault_t;
	localparam fault_t FLT_NONE = 3'd0;
	localparam fault_t FLT_ADEL = 3'd1;
	localparam fault_t FLT_ADES = 3'd2;
	localparam fault_t FLT_TLBL = 3'd3;
	localparam fault_t FLT_TLBS = 3'd4;
	localparam fault_t FLT_MOD  = 3'd5;

	// bit positions inside the N D V G flag nibble
	localparam int FLAG_G = 0;
	localparam int FLAG_V = 1;
	localparam int FLAG_D = 2;
	localparam int FLAG_N = 3;

	// top three address bits of the unmapped kernel segments
	localparam logic [2:0] SEG_KSEG0 = 3'b100;
	localparam logic [2:0] SEG_KSEG1 = 3'b101;

	typedef struct packed {
		op_t               op;
		logic [VA_W-1:0]   vaddr;
		logic              is_store;
		logic              in_kernel;
		logic [ASID_W-1:0] asid;
		logic [SLOT_W-1:0] entry_index;
		logic [VPN_W-1:0]  entry_vpn;
		logic [PFN_W-1:0]  entry_pfn;
		logic [FLAG_W-1:0] entry_flags;
	} req_t;

	typedef struct packed {
		logic [VA_W-1:0]   paddr;
		logic              cacheable;
		fault_t            fault;
		logic              user_refill;
		logic              probe_found;
		logic [SLOT_W-1:0] probe_slot;
		logic [VPN_W-1:0]  read_vpn;
		logic [ASID_W-1:0] read_asid;
		logic [PFN_W-1:0]  read_pfn;
		logic [FLAG_W-1:0] read_flags;
	} rsp_t;

	typedef struct packed {
		logic [VPN_W-1:0]  vpn;
		logic [ASID_W-1:0] asid;
	} tag_t;

	typedef struct packed {
		logic [PFN_W-1:0]  pfn;
		logic [FLAG_W-1:0] flags;
	} frame_t;

	// search key broadcast to every cell
	typedef struct packed {
		logic              by_index;
		logic [VPN_W-1:0]  vpn;
		logic [ASID_W-1:0] asid;
		logic [SLOT_W-1:0] idx;
	} key_t;

	// entry write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		tag_t              tag;
		frame_t            frame;
	} wr_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              tok;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		tag_t              tag;
		frame_t            frame;
	} carry_t;

endpackage
`default_nettype wire

// ----- sv/mtlb_cell.sv -----
// One TLB slot: holds its entry and passes the search token on.
`default_nettype none
module mtlb_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mtlb_pkg::key_t  key,
	input  mtlb_pkg::wr_t   wr,
	input  mtlb_pkg::carry_t carry_in,
	output mtlb_pkg::carry_t carry_out
);
	import mtlb_pkg::*;

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	tag_t   tag_q;
	frame_t frame_q;
	carry_t carry_q;
	carry_t carry_d;
	logic   match;

	always_comb begin
		if (key.by_index) begin
			match = (key.idx == MY_SLOT);
		end else begin
			match = (tag_q.vpn == key.vpn) &&
				(frame_q.flags[FLAG_G] || (tag_q.asid == key.asid));
		end
	end

	// first match wins: a token already carrying a hit passes unchanged
	always_comb begin
		carry_d = carry_in;
		if (!carry_in.hit && match) begin
			carry_d.hit   = 1'b1;
			carry_d.slot  = MY_SLOT;
			carry_d.tag   = tag_q;
			carry_d.frame = frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '0;
			frame_q <= '0;
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
			if (wr.en && (wr.idx == MY_SLOT)) begin
				tag_q   <= wr.tag;
				frame_q <= wr.frame;
			end
		end
	end

	assign carry_out = carry_q;

endmodule
`default_nettype wire

// ----- sv/mips_tlb_address_translator_unit.sv -----
// Top level of the R3000-style TLB address translator.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------
//  req     | in        | req_valid / req_ready | mtlb_pkg::req_t (op, vaddr..)
//  rsp     | out       | rsp_valid / rsp_ready | mtlb_pkg::rsp_t (paddr, ..)
//
// Each beat runs a token down a chain of ENTRIES slot cells, one cell per
// cycle; the result is formatted once the token leaves the last cell, and
// no new request beat is taken until the token has left the chain.
// Writes land in the addressed slot on the accept edge itself.
// Reset clears every slot to zero (page 0, asid 0, G and V clear).
// A stalled response waits in the output register, with one more result
// held behind it; a new request is taken meanwhile, but not a third.
`default_nettype none
`include "assert_macros.svh"
module mips_tlb_address_translator_unit #(
	parameter int ENTRIES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mtlb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mtlb_pkg::rsp_t rsp
);
	import mtlb_pkg::*;

	// control
	logic   busy_q;       // a token is travelling the chain
	logic   launch_q;     // token enters cell 0
	logic   out_valid_q;
	logic   pend_valid_q; // second finished result behind the output
	logic   accept;
	logic   done;

	// payload
	req_t   req_q;
	rsp_t   out_q;
	rsp_t   pend_q;
	rsp_t   res;

	key_t   key;
	wr_t    wr;
	carry_t chain [ENTRIES+1];
	carry_t last;
	logic [ENTRIES:0] tok_vec;

	assign accept    = req_valid && req_ready;
	assign req_ready = !busy_q && !pend_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// entry write goes straight from the port on the accept edge
	always_comb begin
		wr.en        = accept && (req.op == OP_WRITE);
		wr.idx       = req.entry_index;
		wr.tag.vpn   = req.entry_vpn;
		wr.tag.asid  = req.asid;
		wr.frame.pfn = req.entry_pfn;
		wr.frame.flags = req.entry_flags;
	end

	// search key from the held request: translate uses the page of vaddr,
	// probe uses entry_vpn, read selects by slot number
	always_comb begin
		key.by_index = (req_q.op == OP_READ);
		key.vpn      = (req_q.op == OP_TRANSLATE) ? req_q.vaddr[VA_W-1:OFF_W]
			: req_q.entry_vpn;
		key.asid     = req_q.asid;
		key.idx      = req_q.entry_index;
	end

	always_comb begin
		chain[0]     = '0;
		chain[0].tok = launch_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		mtlb_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.wr       (wr),
			.carry_in (chain[i]),
			.carry_out(chain[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_tok
		assign tok_vec[i] = chain[i].tok;
	end

	assign last = chain[ENTRIES];
	assign done = last.tok;

	// result formatting once the token leaves the last cell
	always_comb begin
		res = '0;
		unique case (req_q.op)
			OP_TRANSLATE: begin
				res.paddr = '1;
				if (req_q.in_kernel && (req_q.vaddr[VA_W-1:VA_W-3] == SEG_KSEG0)) begin
					// kseg0: unmapped, cached
					res.paddr     = {3'b000, req_q.vaddr[VA_W-4:0]};
					res.cacheable = 1'b1;
				end else if (req_q.in_kernel &&
					(req_q.vaddr[VA_W-1:VA_W-3] == SEG_KSEG1)) begin
					// kseg1: unmapped, uncached
					res.paddr = {3'b000, req_q.vaddr[VA_W-4:0]};
				end else if (!req_q.in_kernel && req_q.vaddr[VA_W-1]) begin
					res.fault = req_q.is_store ? FLT_ADES : FLT_ADEL;
				end else if (!last.hit) begin
					res.fault       = req_q.is_store ? FLT_TLBS : FLT_TLBL;
					res.user_refill = !req_q.vaddr[VA_W-1];
				end else if (!last.frame.flags[FLAG_V]) begin
					res.fault = req_q.is_store ? FLT_TLBS : FLT_TLBL;
				end else if (req_q.is_store && !last.frame.flags[FLAG_D]) begin
					res.fault = FLT_MOD;
				end else begin
					res.paddr     = {last.frame.pfn, req_q.vaddr[OFF_W-1:0]};
					res.cacheable = !last.frame.flags[FLAG_N];
				end
			end
			OP_READ: begin
				if (last.hit) begin
					res.read_vpn   = last.tag.vpn;
					res.read_asid  = last.tag.asid;
					res.read_pfn   = last.frame.pfn;
					res.read_flags = last.frame.flags;
				end
			end
			OP_WRITE: begin
				res = '0;
			end
			OP_PROBE: begin
				if (last.hit) begin
					res.probe_found = 1'b1;
					res.probe_slot  = last.slot;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			launch_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			launch_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			priority if (done) begin
				if (!out_valid_q || rsp_ready) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (out_valid_q && rsp_ready) begin
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		priority if (done) begin
			if (!out_valid_q || rsp_ready) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (out_valid_q && rsp_ready && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	// checks
	`AST_ALW(a_one_token, $onehot0(tok_vec), "more than one search token in the chain")
	`AST_IMP(a_done_busy, done, busy_q, "token left the chain with no request in flight")
	`AST_NXT(a_accept_busy, accept, busy_q && launch_q, "accepted beat did not launch a token")
	`AST_IMP(a_pend_out, pend_valid_q, out_valid_q, "held result behind an empty output")

endmodule
`default_nettype wire

// ----- tb/tb_mips_tlb_address_translator_unit.sv -----
// Self-checking testbench for the R3000-style TLB address translator.
`timescale 1ns / 100ps

class tlb_scoreboard #(int SLOTS = 64);
	localparam logic [31:0] KSEG0_BASE = 32'h8000_0000;
	localparam logic [31:0] KSEG1_BASE = 32'ha000_0000;

	mtlb_pkg::tag_t   tags[SLOTS];
	mtlb_pkg::frame_t frames[SLOTS];
	mtlb_pkg::rsp_t   expected_q[$];
	int               errors;

	function new();
		foreach (tags[i]) begin
			tags[i]   = '0;
			frames[i] = '0;
		end
		errors = 0;
	endfunction

	// lowest slot with matching page that is global or owned by id
	function bit lookup(input logic [19:0] vpn, input logic [5:0] id, output int slot);
		slot = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (tags[i].vpn == vpn &&
			    (frames[i].flags[mtlb_pkg::FLAG_G] || tags[i].asid == id)) begin
				slot = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function mtlb_pkg::rsp_t compute_response(mtlb_pkg::req_t r);
		mtlb_pkg::rsp_t   o;
		mtlb_pkg::frame_t fr;
		int               slot;
		bit               hit;
		o = '0;
		case (r.op)
			mtlb_pkg::OP_TRANSLATE: begin
				o.paddr = '1;
				if (r.in_kernel && r.vaddr[31:29] == mtlb_pkg::SEG_KSEG0) begin
					o.paddr     = r.vaddr - KSEG0_BASE;
					o.cacheable = 1'b1;
				end else if (r.in_kernel && r.vaddr[31:29] == mtlb_pkg::SEG_KSEG1) begin
					o.paddr = r.vaddr - KSEG1_BASE;
				end else if (!r.in_kernel && r.vaddr[31]) begin
					o.fault = r.is_store ? mtlb_pkg::FLT_ADES : mtlb_pkg::FLT_ADEL;
				end else begin
					hit = lookup(r.vaddr[31:12], r.asid, slot);
					fr  = frames[slot];
					if (!hit) begin
						o.fault       = r.is_store ? mtlb_pkg::FLT_TLBS : mtlb_pkg::FLT_TLBL;
						o.user_refill = !r.vaddr[31];
					end else if (!fr.flags[mtlb_pkg::FLAG_V]) begin
						o.fault = r.is_store ? mtlb_pkg::FLT_TLBS : mtlb_pkg::FLT_TLBL;
					end else if (r.is_store && !fr.flags[mtlb_pkg::FLAG_D]) begin
						o.fault = mtlb_pkg::FLT_MOD;
					end else begin
						o.paddr     = {fr.pfn, r.vaddr[11:0]};
						o.cacheable = !fr.flags[mtlb_pkg::FLAG_N];
					end
				end
			end
			mtlb_pkg::OP_READ: begin
				if (r.entry_index < SLOTS) begin
					o.read_vpn   = tags[r.entry_index].vpn;
					o.read_asid  = tags[r.entry_index].asid;
					o.read_pfn   = frames[r.entry_index].pfn;
					o.read_flags = frames[r.entry_index].flags;
				end
			end
			mtlb_pkg::OP_WRITE: begin
				if (r.entry_index < SLOTS) begin
					tags[r.entry_index]   = {r.entry_vpn, r.asid};
					frames[r.entry_index] = {r.entry_pfn, r.entry_flags};
				end
			end
			mtlb_pkg::OP_PROBE: begin
				hit           = lookup(r.entry_vpn, r.asid, slot);
				o.probe_found = hit;
				o.probe_slot  = hit ? 6'(slot) : '0;
			end
		endcase
		return o;
	endfunction

	function void note_request(mtlb_pkg::req_t r);
		expected_q.push_back(compute_response(r));
	endfunction

	function int field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v === got_v)
			return 0;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
		return 1;
	endfunction

	function void check_response(mtlb_pkg::rsp_t got);
		mtlb_pkg::rsp_t e;
		int             bad;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: response beat with nothing outstanding, expected none, actual %h",
			         $time, got);
			return;
		end
		e   = expected_q.pop_front();
		bad = 0;
		bad += field_check("paddr",       e.paddr,       got.paddr);
		bad += field_check("cacheable",   e.cacheable,   got.cacheable);
		bad += field_check("fault",       e.fault,       got.fault);
		bad += field_check("user_refill", e.user_refill, got.user_refill);
		bad += field_check("probe_found", e.probe_found, got.probe_found);
		bad += field_check("probe_slot",  e.probe_slot,  got.probe_slot);
		bad += field_check("read_vpn",    e.read_vpn,    got.read_vpn);
		bad += field_check("read_asid",   e.read_asid,   got.read_asid);
		bad += field_check("read_pfn",    e.read_pfn,    got.read_pfn);
		bad += field_check("read_flags",  e.read_flags,  got.read_flags);
		errors += bad;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_mips_tlb_address_translator_unit;
	import mtlb_pkg::*;

	localparam int SLOTS       = 64;
	// receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD   = 400;
	// cycles with no beat on either channel before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// settle time after the last expected response
	localparam int TAIL        = 2 * SLOTS + 8;
	localparam int PHASE_ITEMS = 175;

	localparam logic [FLAG_W-1:0] FL_G = 4'(1 << FLAG_G);
	localparam logic [FLAG_W-1:0] FL_V = 4'(1 << FLAG_V);
	localparam logic [FLAG_W-1:0] FL_D = 4'(1 << FLAG_D);
	localparam logic [FLAG_W-1:0] FL_N = 4'(1 << FLAG_N);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit hold_go      = 1'b0;
	int quiet_cycles = 0;

	// small pools of pages and asids so random traffic keeps hitting the TLB
	logic [VPN_W-1:0]  page_pool[8];
	logic [ASID_W-1:0] asid_pool[4];

	tlb_scoreboard #(SLOTS) sb;

	mips_tlb_address_translator_unit #(
		.ENTRIES(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Beat builders
	// ------------------------------------------------------------------
	function automatic req_t xlate(logic [31:0] va, logic st, logic kern, logic [5:0] id);
		req_t r = '0;
		r.op          = OP_TRANSLATE;
		r.vaddr       = va;
		r.is_store    = st;
		r.in_kernel   = kern;
		r.asid        = id;
		return r;
	endfunction

	function automatic req_t wr(logic [5:0] idx, logic [19:0] vpn, logic [5:0] id,
	                            logic [19:0] pfn, logic [3:0] flags);
		req_t r = '0;
		r.op          = OP_WRITE;
		r.entry_index = idx;
		r.entry_vpn   = vpn;
		r.asid        = id;
		r.entry_pfn   = pfn;
		r.entry_flags = flags;
		return r;
	endfunction

	function automatic req_t rd(logic [5:0] idx);
		req_t r = '0;
		r.op          = OP_READ;
		r.entry_index = idx;
		return r;
	endfunction

	function automatic req_t probe(logic [19:0] vpn, logic [5:0] id);
		req_t r = '0;
		r.op        = OP_PROBE;
		r.entry_vpn = vpn;
		r.asid      = id;
		return r;
	endfunction

	function automatic logic [VPN_W-1:0] pick_page();
		if ($urandom_range(99) < 85)
			return page_pool[$urandom_range(7)];
		return VPN_W'($urandom);
	endfunction

	function automatic logic [ASID_W-1:0] pick_asid();
		if ($urandom_range(99) < 85)
			return asid_pool[$urandom_range(3)];
		return ASID_W'($urandom);
	endfunction

	// Random beat: every field gets noise, then the fields the op uses are
	// steered toward the page/asid pools so lookups hit written slots.
	function automatic req_t random_beat();
		req_t        r;
		int unsigned pick;
		r.vaddr       = $urandom;
		r.is_store    = 1'($urandom_range(1));
		r.in_kernel   = 1'($urandom_range(1));
		r.asid        = ASID_W'($urandom);
		r.entry_index = SLOT_W'($urandom);
		r.entry_vpn   = VPN_W'($urandom);
		r.entry_pfn   = PFN_W'($urandom);
		r.entry_flags = FLAG_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			r.op = OP_TRANSLATE;
			if ($urandom_range(99) < 80)
				r.vaddr = {pick_page(), r.vaddr[OFF_W-1:0]};
			r.asid = pick_asid();
		end else if (pick < 65) begin
			r.op        = OP_WRITE;
			r.entry_vpn = pick_page();
			r.asid      = pick_asid();
			if ($urandom_range(3) != 0)
				r.entry_flags[FLAG_V] = 1'b1;
		end else if (pick < 80) begin
			r.op = OP_READ;
		end else begin
			r.op        = OP_PROBE;
			r.entry_vpn = pick_page();
			r.asid      = pick_asid();
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side: drive at the falling edge, finish on the accept edge.
	// When idling, the gap length is spread over a whole pass through the
	// slot chain so the next offer can land at any point of the work.
	// ------------------------------------------------------------------
	task automatic send_beat(input req_t r);
		int gap;
		gap = 0;
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct)
			gap = $urandom_range(1, SLOTS + 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// Sender stops offering until every outstanding response is back.
	task automatic pause_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int n, input bit with_hold);
		for (int i = 0; i < n; i++) begin
			// hold_go is raised on an accept edge; the receiver picks it up
			// at the following falling edge
			if (with_hold && i == n / 3)
				hold_go = 1'b1;
			send_beat(random_beat());
		end
	endtask

	// ------------------------------------------------------------------
	// Response side: ready changes at the falling edge; a long hold-off is
	// counted here so the sender keeps pushing while the block backs up.
	// ------------------------------------------------------------------
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Beat monitors, sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			sb.note_request(req);
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	// Hang detector: any beat on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_mips_tlb_address_translator_unit: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;

		for (int i = 0; i < 3; i++)
			page_pool[i] = {1'b0, 19'($urandom)};
		page_pool[3] = '0;
		page_pool[4] = {2'b11, 18'($urandom)};
		page_pool[5] = {2'b11, 18'($urandom)};
		page_pool[6] = {SEG_KSEG0, 17'($urandom)};
		page_pool[7] = {SEG_KSEG1, 17'($urandom)};
		asid_pool[0] = '0;
		asid_pool[1] = '1;
		asid_pool[2] = ASID_W'($urandom);
		asid_pool[3] = ASID_W'($urandom);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// phase 1: sender idles a little, receiver stalls a lot
		tx_idle_pct  = 23;
		rx_stall_pct = 60;

		// Directed: the cleared TLB first. Slot 0 reads as page 0, asid 0,
		// not valid, so page 0 with asid 0 hits it and faults.
		send_beat(xlate(32'h0000_0000, 1'b0, 1'b0, 6'd0));
		send_beat(xlate(32'h0000_0000, 1'b1, 1'b1, 6'd0));
		send_beat(probe(20'h00000, 6'd0));
		send_beat(rd(6'd63));
		// slot 63 private to asid 5, slot 1 global on the same page: the
		// lower slot wins
		send_beat(wr(6'd63, 20'h00400, 6'd5, 20'hfffff, FL_N | FL_D | FL_V));
		send_beat(wr(6'd1, 20'h00400, 6'd7, 20'h12345, FL_V | FL_G));
		send_beat(wr(6'd2, 20'hfffff, 6'd63, 20'h00000, FL_D | FL_V));
		send_beat(wr(6'd3, 20'h7ffff, 6'd9, 20'habcde, '0));
		send_beat(xlate(32'h0040_0abc, 1'b0, 1'b0, 6'd5));  // global hit
		send_beat(xlate(32'h0040_0fff, 1'b1, 1'b0, 6'd5));  // store to clean page
		send_beat(xlate(32'hffff_f000, 1'b1, 1'b1, 6'd63)); // kseg2 hit
		send_beat(xlate(32'hffff_ffff, 1'b0, 1'b1, 6'd0));  // kseg2 miss, no refill
		send_beat(xlate(32'h7fff_f123, 1'b0, 1'b0, 6'd9));  // invalid slot
		send_beat(xlate(32'h7fff_f123, 1'b1, 1'b0, 6'd10)); // kuseg miss, refill
		send_beat(xlate(32'h8000_0000, 1'b0, 1'b1, 6'd0));  // kseg0 edges
		send_beat(xlate(32'h9fff_ffff, 1'b1, 1'b1, 6'd0));
		send_beat(xlate(32'ha000_0000, 1'b0, 1'b1, 6'd0));  // kseg1 edges
		send_beat(xlate(32'hbfff_ffff, 1'b1, 1'b1, 6'd0));
		send_beat(xlate(32'h8000_0000, 1'b0, 1'b0, 6'd0));  // user load, upper half
		send_beat(xlate(32'hffff_ffff, 1'b1, 1'b0, 6'd0));  // user store, upper half
		// drop the global slot: the private noncacheable slot takes over
		send_beat(wr(6'd1, 20'h00400, 6'd7, 20'h12345, '0));
		send_beat(xlate(32'h0040_0abc, 1'b1, 1'b0, 6'd5));
		send_beat(rd(6'd63));
		send_beat(probe(20'h00400, 6'd5));
		send_beat(probe(20'h12345, 6'd1));                  // probe miss
		send_beat(wr(6'd0, '1, '1, '1, '1));
		send_beat(rd(6'd0));

		// random traffic with one long receiver hold-off in the middle
		run_random(PHASE_ITEMS, 1'b1);
		pause_until_drained();

		// phase 2: roles swapped
		tx_idle_pct  = 60;
		rx_stall_pct = 23;
		run_random(PHASE_ITEMS, 1'b0);
		pause_until_drained();

		// phase 3: back to back on both sides
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		run_random(PHASE_ITEMS, 1'b0);
		pause_until_drained();

		// let any stray response show up before the verdict
		repeat (TAIL) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d responses still outstanding, expected 0", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_mips_tlb_address_translator_unit: clean");
		end else begin
			$display("tb_mips_tlb_address_translator_unit: errors");
		end
		$finish;
	end

endmodule
